[design/postfix_expression_evaluator_core_macros.svh]
// ----------------------------------------------------------------------------
// Postfix evaluator assertion macros
// Shorthand for clocked assertions that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PFE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared sizes, character and status codes, and controller interface types.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int DATA_W      = 32;
    localparam int SYM_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_DIV   = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic                load_item;
        logic                push;
        logic                alu_pop;
        logic                zero_pop;
        logic                div_start;
        logic                div_pop;
        logic                note_err;
        logic [STATUS_W-1:0] err_code;
        logic                emit;
    } pfe_cmd_t;

    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic is_div;
        logic full;
        logic lt2;
        logic right_zero;
        logic div_done;
        logic last;
        logic out_busy;
    } pfe_stat_t;

endpackage

[design/pfe_divider.sv]
// ----------------------------------------------------------------------------
// Postfix evaluator divider
// Signed 32-bit division truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfe_divider
    import pfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;
    logic [DATA_W:0]      rem_reg;
    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    mag_b_reg;

    logic [DATA_W:0]      rem_shift;
    logic [DATA_W:0]      diff;
    logic [DATA_W-1:0]    mag_a;
    logic [DATA_W-1:0]    mag_b;

    assign mag_a     = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
    assign mag_b     = divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
    assign rem_shift = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
    assign diff      = rem_shift - {1'b0, mag_b_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The dividend magnitude shifts out of the quotient register as the
    // quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            rem_reg   <= '0;
            quo_reg   <= mag_a;
            mag_b_reg <= mag_b;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + DATA_W'(1)) : quo_reg;

endmodule

[design/pfe_datapath.sv]
// ----------------------------------------------------------------------------
// Postfix evaluator datapath
// Operand stack, arithmetic unit, error tracking and the result register.
// ----------------------------------------------------------------------------
module pfe_datapath
    import pfe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  pfe_cmd_t            cmd,
    output pfe_stat_t           stat,
    input  logic [SYM_W-1:0]    symbol,
    input  logic                last_symbol,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [DATA_W-1:0]   value,
    output logic [STATUS_W-1:0] status
);

    // The top of stack lives in top_reg; entries below it live in stack_mem.
    logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic [DATA_W-1:0]   top_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [STATUS_W-1:0] sticky_reg;
    logic [SYM_W-1:0]    sym_reg;
    logic                last_reg;
    logic                result_valid_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [PTR_W-1:0]    rd_addr;
    logic [PTR_W-1:0]    wr_addr;
    logic                mem_we;
    logic [SYM_W-1:0]    sym_off;
    logic [DATA_W-1:0]   alu_result;
    logic [DATA_W-1:0]   quotient;
    logic                div_done;
    logic [STATUS_W-1:0] final_status;

    assign rd_addr = PTR_W'(count_reg - CNT_W'(2));
    assign wr_addr = PTR_W'(count_reg - CNT_W'(1));
    assign mem_we  = cmd.push && (count_reg != '0);
    assign sym_off = sym_reg - SYM_ZERO;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= top_reg;
        end
        if (cmd.load_item)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    always_comb
    begin
        case (sym_reg)
            SYM_PLUS:  alu_result = rd_data_reg + top_reg;
            SYM_MINUS: alu_result = rd_data_reg - top_reg;
            default:   alu_result = rd_data_reg * top_reg;
        endcase
    end

    pfe_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_data_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        if (sticky_reg != ST_OK)
        begin
            final_status = sticky_reg;
        end
        else if (count_reg == '0)
        begin
            final_status = ST_EMPTY;
        end
        else
        begin
            final_status = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            sym_reg  <= symbol;
            last_reg <= last_symbol;
        end
        if (cmd.push)
        begin
            top_reg <= DATA_W'(sym_off[3:0]);
        end
        else if (cmd.alu_pop)
        begin
            top_reg <= alu_result;
        end
        else if (cmd.zero_pop)
        begin
            top_reg <= '0;
        end
        else if (cmd.div_pop)
        begin
            top_reg <= quotient;
        end
        if (cmd.emit)
        begin
            value_reg  <= (count_reg != '0) ? top_reg : '0;
            status_reg <= final_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            sticky_reg       <= ST_OK;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                count_reg  <= '0;
                sticky_reg <= ST_OK;
            end
            else
            begin
                if (cmd.push)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else if (cmd.alu_pop || cmd.zero_pop || cmd.div_pop)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
                if (cmd.note_err && (sticky_reg == ST_OK))
                begin
                    sticky_reg <= cmd.err_code;
                end
            end

            if (cmd.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_digit   = (sym_reg >= SYM_ZERO) && (sym_reg <= SYM_NINE);
    assign stat.is_op      = (sym_reg == SYM_PLUS) || (sym_reg == SYM_MINUS) ||
                             (sym_reg == SYM_MUL) || (sym_reg == SYM_DIV);
    assign stat.is_div     = (sym_reg == SYM_DIV);
    assign stat.full       = (count_reg == CNT_W'(STACK_DEPTH));
    assign stat.lt2        = (count_reg < CNT_W'(2));
    assign stat.right_zero = (top_reg == '0);
    assign stat.div_done   = div_done;
    assign stat.last       = last_reg;
    assign stat.out_busy   = result_valid_reg && !result_ready;

    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign status       = status_reg;

endmodule

[design/pfe_ctrl.sv]
// ----------------------------------------------------------------------------
// Postfix evaluator controller
// Sequences accept, execute and finish steps for each character, with a divide step for a division.
// ----------------------------------------------------------------------------
module pfe_ctrl
    import pfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  pfe_stat_t stat,
    output pfe_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.err_code = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                if (stat.is_digit)
                begin
                    if (stat.full)
                    begin
                        cmd.note_err = 1'b1;
                        cmd.err_code = ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                end
                else if (stat.is_op)
                begin
                    if (stat.lt2)
                    begin
                        cmd.note_err = 1'b1;
                        cmd.err_code = ST_UNDERFLOW;
                    end
                    else if (stat.is_div)
                    begin
                        if (stat.right_zero)
                        begin
                            cmd.note_err = 1'b1;
                            cmd.err_code = ST_DIVZERO;
                            cmd.zero_pop = 1'b1;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    else
                    begin
                        cmd.alu_pop = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_pop = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_FIN:
            begin
                // A result waits here until the output register is free.
                if (!stat.last)
                begin
                    state_next = S_IDLE;
                end
                else if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign item_ready = (state_reg == S_IDLE);

endmodule

[design/postfix_expression_evaluator_core.sv]
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a postfix expression given one ASCII character per transfer.
// ----------------------------------------------------------------------------
// Each character passes through accept, execute and finish steps before the
// next one is taken; a division adds a divide step after execute, in which
// the divider produces one quotient bit per cycle. A character marked last
// loads the result register and may wait in the finish step while an earlier
// result is still untaken. Digits push onto a 32-entry operand stack, + - * /
// pop two operands and push the 32-bit wrapped result, and the last character
// returns the top of stack with the first error seen, then empties the stack.

module postfix_expression_evaluator_core
    import pfe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [SYM_W-1:0]    symbol,
    input  logic                last_symbol,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [DATA_W-1:0]   value,
    output logic [STATUS_W-1:0] status
);

    pfe_cmd_t  cmd;
    pfe_stat_t stat;

    pfe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    pfe_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .symbol       (symbol),
        .last_symbol  (last_symbol),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .status       (status)
    );

endmodule

[design/pfe_checker.sv]
// ----------------------------------------------------------------------------
// Postfix evaluator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_core_macros.svh"

module pfe_checker
    import pfe_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input logic [DATA_W-1:0]   value,
    input logic [STATUS_W-1:0] status
);

    // A stalled result keeps its fields.
    `PFE_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(value) && $stable(status), "result changed while stalled")

    // An empty stack at the end always reads as zero.
    `PFE_ASSERT_SAME(a_empty_zero, result_valid && (status == ST_EMPTY), value == '0, "empty status with nonzero value")

    // The block works on one character at a time after a transfer.
    `PFE_ASSERT_NEXT(a_busy_after_take, item_valid && item_ready, !item_ready, "input taken on consecutive cycles")

endmodule

bind postfix_expression_evaluator_core pfe_checker u_pfe_checker (.*);
